// ===== sv/alu_pkg.sv =====
// Package with the shared widths, opcodes and pipeline depth of the integer ALU.
`default_nettype none
package alu_pkg;
    localparam int WIDTH = 32;
    localparam int DIV_STEPS = WIDTH;
    localparam int STAGES = DIV_STEPS + 2;
    localparam int LAST = STAGES - 1;

    typedef logic [1:0] opcode_t;
    typedef logic [WIDTH-1:0] word_t;

    localparam opcode_t OP_ADD = 2'd0;
    localparam opcode_t OP_SUB = 2'd1;
    localparam opcode_t OP_MUL = 2'd2;
    localparam opcode_t OP_DIV = 2'd3;
endpackage
`default_nettype wire

// ===== sv/integer_alu_with_nzcv_flags.sv =====
// Top level of the pipelined 32-bit integer ALU with NZCV flags.
//
// The block takes one word per cycle on the input channel (in_valid, in_ready)
// while in_ready is high, carrying an opcode and two operands, and returns one
// word per operation on the output channel (out_valid, out_ready) with the
// result and its flags. Every operation travels the same pipeline of 34
// register stages, for add, subtract, multiply and divide alike, and the
// results leave in the order the operations arrived.
// Throughput is one operation per cycle while the receiver does not stall.
// The depth is set by the unsigned divider, which produces one quotient bit
// in each of 32 restoring stages.
// Add, subtract and the low-word multiply finish in the entry stage and then
// ride along with the divider stages unchanged.
// When the receiver stalls, the whole pipeline holds: in_ready drops in the
// same cycle, so no word is lost or repeated. A bubble at the output still
// lets the pipeline advance.
// Reset clears every stage's valid bit; the data registers need no reset.
// A divide by zero returns result 0 with zero_flag and div_by_zero set.
`default_nettype none
module integer_alu_with_nzcv_flags
    import alu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       opcode,
    input  wire logic [WIDTH-1:0] operand_a,
    input  wire logic [WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      result,
    output logic                  zero_flag,
    output logic                  negative_flag,
    output logic                  carry_flag,
    output logic                  overflow_flag,
    output logic                  div_by_zero
);
    // Per-stage state. rem holds the partial remainder, quo shifts the
    // dividend out at the top while the quotient bits enter at the bottom.
    logic    valid_reg [STAGES];
    logic    valid_next[STAGES];
    opcode_t op_reg    [STAGES];
    opcode_t op_next   [STAGES];
    word_t   rem_reg   [STAGES];
    word_t   rem_next  [STAGES];
    word_t   quo_reg   [STAGES];
    word_t   quo_next  [STAGES];
    word_t   dvs_reg   [STAGES];
    word_t   dvs_next  [STAGES];
    word_t   res_reg   [STAGES];
    word_t   res_next  [STAGES];
    logic    c_reg     [STAGES];
    logic    c_next    [STAGES];
    logic    v_reg     [STAGES];
    logic    v_next    [STAGES];
    logic    dz_reg    [STAGES];
    logic    dz_next   [STAGES];

    logic               advance;
    logic [WIDTH:0]     sum;
    word_t              b_eff;
    logic [2*WIDTH-1:0] product;
    logic [WIDTH:0]     trial  [STAGES];
    logic               fits   [STAGES];
    word_t              final_res;

    // The pipeline moves whenever the output word is taken or absent.
    assign advance  = !valid_reg[LAST] || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        b_eff   = (opcode == OP_SUB) ? ~operand_b : operand_b;
        sum     = {1'b0, operand_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, opcode == OP_SUB};
        product = operand_a * operand_b;
        final_res = (op_reg[LAST-1] == OP_DIV) ?
                    (dz_reg[LAST-1] ? '0 : quo_reg[LAST-1]) : res_reg[LAST-1];

        for (int s = 0; s < STAGES; s++)
        begin
            valid_next[s] = valid_reg[s];
            op_next[s]    = op_reg[s];
            rem_next[s]   = rem_reg[s];
            quo_next[s]   = quo_reg[s];
            dvs_next[s]   = dvs_reg[s];
            res_next[s]   = res_reg[s];
            c_next[s]     = c_reg[s];
            v_next[s]     = v_reg[s];
            dz_next[s]    = dz_reg[s];
            trial[s]      = '0;
            fits[s]       = 1'b0;
        end

        if (advance)
        begin
            // Entry stage: adder, multiplier and divider setup.
            valid_next[0] = in_valid;
            op_next[0]    = opcode;
            rem_next[0]   = '0;
            quo_next[0]   = operand_a;
            dvs_next[0]   = operand_b;
            dz_next[0]    = (opcode == OP_DIV) && (operand_b == '0);
            c_next[0]     = 1'b0;
            v_next[0]     = 1'b0;
            case (opcode)
                OP_ADD:
                begin
                    res_next[0] = sum[WIDTH-1:0];
                    c_next[0]   = sum[WIDTH];
                    v_next[0]   = (operand_a[WIDTH-1] == operand_b[WIDTH-1]) &&
                                  (sum[WIDTH-1] != operand_a[WIDTH-1]);
                end
                OP_SUB:
                begin
                    res_next[0] = sum[WIDTH-1:0];
                    c_next[0]   = sum[WIDTH];
                    v_next[0]   = (operand_a[WIDTH-1] != operand_b[WIDTH-1]) &&
                                  (sum[WIDTH-1] != operand_a[WIDTH-1]);
                end
                OP_MUL:  res_next[0] = product[WIDTH-1:0];
                default: res_next[0] = '0;
            endcase

            // Divider stages: one restoring step each.
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                trial[s] = {rem_reg[s-1], quo_reg[s-1][WIDTH-1]} - {1'b0, dvs_reg[s-1]};
                fits[s]  = !trial[s][WIDTH];
                valid_next[s] = valid_reg[s-1];
                op_next[s]    = op_reg[s-1];
                rem_next[s]   = fits[s] ? trial[s][WIDTH-1:0] :
                                {rem_reg[s-1][WIDTH-2:0], quo_reg[s-1][WIDTH-1]};
                quo_next[s]   = {quo_reg[s-1][WIDTH-2:0], fits[s]};
                dvs_next[s]   = dvs_reg[s-1];
                res_next[s]   = res_reg[s-1];
                c_next[s]     = c_reg[s-1];
                v_next[s]     = v_reg[s-1];
                dz_next[s]    = dz_reg[s-1];
            end

            // Output stage: pick the result; carry, overflow and divide-by-zero pass through.
            valid_next[LAST] = valid_reg[LAST-1];
            op_next[LAST]    = op_reg[LAST-1];
            rem_next[LAST]   = rem_reg[LAST-1];
            quo_next[LAST]   = quo_reg[LAST-1];
            dvs_next[LAST]   = dvs_reg[LAST-1];
            res_next[LAST]   = final_res;
            c_next[LAST]     = c_reg[LAST-1];
            v_next[LAST]     = v_reg[LAST-1];
            dz_next[LAST]    = dz_reg[LAST-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            op_reg[s]  <= op_next[s];
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            dvs_reg[s] <= dvs_next[s];
            res_reg[s] <= res_next[s];
            c_reg[s]   <= c_next[s];
            v_reg[s]   <= v_next[s];
            dz_reg[s]  <= dz_next[s];
        end
    end

    assign out_valid     = valid_reg[LAST];
    assign result        = res_reg[LAST];
    assign zero_flag     = (res_reg[LAST] == '0);
    assign negative_flag = res_reg[LAST][WIDTH-1];
    assign carry_flag    = c_reg[LAST];
    assign overflow_flag = v_reg[LAST];
    assign div_by_zero   = dz_reg[LAST];
endmodule
`default_nettype wire

// ===== sv/alu_checker.sv =====
// Port-level checker for the integer ALU and its bind statement.
`default_nettype none
module alu_checker
    import alu_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [WIDTH-1:0] result,
    input wire logic             zero_flag,
    input wire logic             negative_flag,
    input wire logic             carry_flag,
    input wire logic             overflow_flag,
    input wire logic             div_by_zero
);
    // A stalled output word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("output word changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the full pipeline is stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (zero_flag == (result == '0)) &&
                      (negative_flag == result[WIDTH-1]))
        else $error("zero or negative flag disagrees with the result");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> zero_flag && !carry_flag && !overflow_flag)
        else $error("divide by zero word has wrong flags");
endmodule

bind integer_alu_with_nzcv_flags alu_checker u_alu_checker (.*);
`default_nettype wire
